// ===== hdl/refw_pkg.sv =====
`timescale 1ns / 1ps

package refw_pkg;

  localparam int unsigned FadeMax  = 32;
  localparam int unsigned WeightW  = 32;
  localparam int unsigned FrameW   = 16;
  localparam int unsigned PosW     = 6;
  localparam int unsigned AddrW    = $clog2(FadeMax);
  localparam int unsigned ProdW    = WeightW + PosW;
  localparam int unsigned StepW    = $clog2(WeightW);

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [FrameW-1:0]  frame;
    logic [PosW-1:0]    start_pos;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

// ===== hdl/refw_ifs.sv =====
`timescale 1ns / 1ps

interface refw_in_if;
  logic                         valid;
  logic                         ready;
  logic                         first_frame;
  logic                         last_frame;
  logic                         present;
  logic [refw_pkg::WeightW-1:0] weight_in;

  modport source (output valid, first_frame, last_frame, present, weight_in, input ready);
  modport sink (input valid, first_frame, last_frame, present, weight_in, output ready);
endinterface

interface refw_out_if;
  logic                         valid;
  logic                         ready;
  logic [refw_pkg::WeightW-1:0] weight_out;
  logic [refw_pkg::FrameW-1:0]  frame_index;
  logic                         last_result;

  modport source (output valid, weight_out, frame_index, last_result, input ready);
  modport sink (input valid, weight_out, frame_index, last_result, output ready);
endinterface

interface refw_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [refw_pkg::PosW-1:0] fade_length;

  modport source (output valid, fade_length, input ready);
  modport sink (input valid, fade_length, output ready);
endinterface

// ===== hdl/refw_ram.sv =====
`timescale 1ns / 1ps

module refw_ram #(
  parameter int unsigned DataWidth = 8,
  parameter int unsigned Depth     = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataWidth-1:0]     wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataWidth-1:0]     rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/refw_scale.sv =====
`timescale 1ns / 1ps

// floor(weight * mult / fade), mult < fade: one multiply, then a restoring
// divide that retires one quotient bit per cycle.
module refw_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [refw_pkg::WeightW-1:0] weight_i,
  input  logic [refw_pkg::PosW-1:0]    mult_i,
  input  logic [refw_pkg::PosW-1:0]    fade_i,
  output logic                         done_o,
  output logic [refw_pkg::WeightW-1:0] quot_o
);

  typedef enum logic [1:0] {SC_IDLE, SC_LOAD, SC_DIV} sc_state_e;

  sc_state_e                      state_q;
  logic [refw_pkg::ProdW-1:0]     prod_q;
  logic [refw_pkg::PosW-1:0]      fade_q;
  logic [refw_pkg::PosW-1:0]      rem_q;
  logic [refw_pkg::WeightW-1:0]   dq_q;
  logic [refw_pkg::StepW-1:0]     step_q;
  logic                           done_q;
  logic [refw_pkg::PosW:0]        trial;
  logic                           qbit;

  assign trial  = {rem_q, dq_q[refw_pkg::WeightW-1]};
  assign qbit   = (trial >= {1'b0, fade_q});
  assign done_o = done_q;
  assign quot_o = dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= (state_q == SC_DIV)
                && (step_q == refw_pkg::StepW'(refw_pkg::WeightW - 1));
      unique case (state_q)
        SC_IDLE: begin
          if (start_i) begin
            prod_q  <= refw_pkg::ProdW'(weight_i) * refw_pkg::ProdW'(mult_i);
            fade_q  <= fade_i;
            state_q <= SC_LOAD;
          end
        end
        SC_LOAD: begin
          // high part is below fade since mult < fade
          rem_q   <= prod_q[refw_pkg::ProdW-1:refw_pkg::WeightW];
          dq_q    <= prod_q[refw_pkg::WeightW-1:0];
          step_q  <= '0;
          state_q <= SC_DIV;
        end
        SC_DIV: begin
          rem_q  <= qbit ? refw_pkg::PosW'(trial - {1'b0, fade_q})
                         : trial[refw_pkg::PosW-1:0];
          dq_q   <= {dq_q[refw_pkg::WeightW-2:0], qbit};
          step_q <= step_q + 1'b1;
          if (step_q == refw_pkg::StepW'(refw_pkg::WeightW - 1)) begin
            state_q <= SC_IDLE;
          end
        end
        default: state_q <= SC_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/run_edge_fade_weighting.sv =====
`timescale 1ns / 1ps

// Run edge fade weighting: one frame per input transaction, faded weights out in
// frame order, the last result of a frame flagged. The block takes one frame
// at a time. A result read back from the delay line is passed on as it is when
// its factor is 1; when it is faded it goes through the shared scale unit: one
// 32x6 multiply and a 32-step restoring divide by the fade length. With fade 0
// a weight passes straight through. A run flush emits up to F+1 results, and
// the output side can stall the block. The delay line sits in a 32-entry RAM
// used as a circular buffer; it needs no clearing after reset. Results pass
// through a stage and an output register, so the sequencer keeps working while
// one result waits on the output side; it waits in S_EMIT only while both hold
// a result and the output side stalls.
module run_edge_fade_weighting (
  input  logic        clk_i,
  input  logic        rst_ni,
  refw_in_if.sink     in_if,
  refw_out_if.source  out_if,
  refw_cfg_if.sink    cfg_if
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_READ, S_CALC, S_WAIT, S_EMIT, S_END
  } state_e;

  typedef enum logic [2:0] {
    PH_FIRST, PH_MAIN, PH_POP, PH_LAST, PH_ABS
  } phase_e;

  state_e                         state_q;
  phase_e                         phase_q;
  logic [refw_pkg::PosW-1:0]      fade_len_q;
  logic [refw_pkg::PosW-1:0]      fade_q;
  logic                           first_q;
  logic                           last_q;
  logic                           present_q;
  logic [refw_pkg::WeightW-1:0]   w_in_q;
  logic [refw_pkg::FrameW-1:0]    idx_q;
  logic [refw_pkg::FrameW-1:0]    counter_q;
  logic [refw_pkg::PosW-1:0]      run_pos_q;
  logic                           in_first_q;
  logic [refw_pkg::AddrW-1:0]     head_q;
  logic [refw_pkg::PosW-1:0]      count_q;
  logic                           emit_pop_q;
  logic [refw_pkg::WeightW-1:0]   res_w_q;
  logic [refw_pkg::FrameW-1:0]    res_fr_q;
  logic                           stage_v_q;
  logic [refw_pkg::WeightW-1:0]   stage_w_q;
  logic [refw_pkg::FrameW-1:0]    stage_fr_q;
  logic                           out_v_q;
  logic [refw_pkg::WeightW-1:0]   out_w_q;
  logic [refw_pkg::FrameW-1:0]    out_fr_q;
  logic                           out_last_q;
  logic                           sc_start_q;
  logic [refw_pkg::WeightW-1:0]   sc_w_q;
  logic [refw_pkg::PosW-1:0]      sc_m_q;

  logic                           sc_done;
  logic [refw_pkg::WeightW-1:0]   sc_quot;
  refw_pkg::entry_t               rd_entry;
  refw_pkg::entry_t               wr_entry;
  logic                           ram_we;
  logic [refw_pkg::AddrW-1:0]     ram_waddr;
  logic                           fade_out;
  logic [refw_pkg::PosW-1:0]      mult;
  logic                           out_fire;
  logic                           out_free;
  logic                           out_load;
  logic                           can_pop;

  assign in_if.ready  = (state_q == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid       = out_v_q;
  assign out_if.weight_out  = out_w_q;
  assign out_if.frame_index = out_fr_q;
  assign out_if.last_result = out_last_q;

  assign out_fire = out_v_q && out_if.ready;
  assign out_free = !out_v_q || out_if.ready;
  assign out_load = ((state_q == S_EMIT) || (state_q == S_END)) && stage_v_q && out_free;
  assign can_pop  = (count_q != '0) && (count_q >= fade_q);

  assign fade_out = (phase_q == PH_FIRST) || (phase_q == PH_ABS);

  always_comb begin
    mult = rd_entry.start_pos;
    if (fade_out && (count_q < mult)) begin
      mult = count_q;
    end
  end

  assign wr_entry.weight    = w_in_q;
  assign wr_entry.frame     = idx_q;
  assign wr_entry.start_pos = in_first_q ? refw_pkg::PosW'(refw_pkg::FadeMax) : run_pos_q;
  assign ram_we    = (state_q == S_DECIDE) && (phase_q == PH_POP) && !can_pop
                     && (fade_q != '0);
  assign ram_waddr = head_q + count_q[refw_pkg::AddrW-1:0];

  refw_ram #(
    .DataWidth (refw_pkg::EntryW),
    .Depth     (refw_pkg::FadeMax)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .raddr_i (head_q),
    .rdata_o (rd_entry)
  );

  refw_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sc_start_q),
    .weight_i (sc_w_q),
    .mult_i   (sc_m_q),
    .fade_i   (fade_q),
    .done_o   (sc_done),
    .quot_o   (sc_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_len_q <= '0;
    end else if (cfg_if.valid) begin
      fade_len_q <= cfg_if.fade_length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= PH_FIRST;
      counter_q  <= '0;
      run_pos_q  <= '0;
      in_first_q <= 1'b1;
      head_q     <= '0;
      count_q    <= '0;
      stage_v_q  <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      sc_start_q <= 1'b0;
      emit_pop_q <= 1'b0;
    end else begin
      sc_start_q <= (state_q == S_CALC) && (mult < fade_q);
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_fire) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_if.valid) begin
            first_q   <= in_if.first_frame;
            last_q    <= in_if.last_frame;
            present_q <= in_if.present;
            w_in_q    <= in_if.weight_in;
            fade_q    <= (fade_len_q > refw_pkg::PosW'(refw_pkg::FadeMax))
                         ? refw_pkg::PosW'(refw_pkg::FadeMax) : fade_len_q;
            phase_q   <= PH_FIRST;
            state_q   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          unique case (phase_q)
            PH_FIRST: begin
              if (first_q && (count_q != '0)) begin
                state_q <= S_READ;
              end else begin
                if (first_q) begin
                  run_pos_q  <= '0;
                  in_first_q <= 1'b1;
                  counter_q  <= '0;
                end
                phase_q <= PH_MAIN;
              end
            end
            PH_MAIN: begin
              idx_q     <= counter_q;
              counter_q <= counter_q + 1'b1;
              if (present_q) begin
                if (run_pos_q < refw_pkg::PosW'(refw_pkg::FadeMax)) begin
                  run_pos_q <= run_pos_q + 1'b1;
                end
                phase_q <= PH_POP;
              end else begin
                phase_q <= PH_ABS;
              end
            end
            PH_POP: begin
              if (can_pop) begin
                state_q <= S_READ;
              end else if (fade_q == '0) begin
                // fade disabled: the frame itself goes straight out
                res_w_q    <= w_in_q;
                res_fr_q   <= idx_q;
                emit_pop_q <= 1'b0;
                phase_q    <= PH_LAST;
                state_q    <= S_EMIT;
              end else begin
                count_q <= count_q + 1'b1;
                phase_q <= PH_LAST;
              end
            end
            PH_LAST: begin
              if (!last_q) begin
                state_q <= S_END;
              end else if (count_q != '0) begin
                state_q <= S_READ;
              end else begin
                run_pos_q  <= '0;
                in_first_q <= 1'b0;
                state_q    <= S_END;
              end
            end
            PH_ABS: begin
              if (count_q != '0) begin
                state_q <= S_READ;
              end else begin
                run_pos_q  <= '0;
                in_first_q <= 1'b0;
                state_q    <= S_END;
              end
            end
            default: state_q <= S_END;
          endcase
        end
        S_READ: begin
          state_q <= S_CALC;
        end
        S_CALC: begin
          res_fr_q   <= rd_entry.frame;
          emit_pop_q <= 1'b1;
          if (mult >= fade_q) begin
            res_w_q <= rd_entry.weight;
            state_q <= S_EMIT;
          end else begin
            sc_w_q  <= rd_entry.weight;
            sc_m_q  <= mult;
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (sc_done) begin
            res_w_q <= sc_quot;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!stage_v_q || out_free) begin
            if (stage_v_q) begin
              out_w_q    <= stage_w_q;
              out_fr_q   <= stage_fr_q;
              out_last_q <= 1'b0;
            end
            stage_w_q  <= res_w_q;
            stage_fr_q <= res_fr_q;
            stage_v_q  <= 1'b1;
            if (emit_pop_q) begin
              head_q  <= head_q + 1'b1;
              count_q <= count_q - 1'b1;
            end
            state_q <= S_DECIDE;
          end
        end
        S_END: begin
          // the held-back result is the frame's last one
          if (!stage_v_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_w_q    <= stage_w_q;
            out_fr_q   <= stage_fr_q;
            out_last_q <= 1'b1;
            stage_v_q  <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // Margin after the last result before the block counts as idle:
  // covers the longest frame, a full flush of faded results.
  localparam int unsigned SettleCycles = 1300;

  typedef struct {
    logic [refw_pkg::WeightW-1:0] weight;
    logic [refw_pkg::FrameW-1:0]  frame;
    logic                         last;
  } faded_t;

  typedef struct {
    logic [refw_pkg::WeightW-1:0] weight;
    logic [refw_pkg::FrameW-1:0]  frame;
    int unsigned                  start_pos;
  } held_t;

  typedef enum logic {ROW_FRAME, ROW_FADE} row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    logic                         first_f;
    logic                         last_f;
    logic                         present;
    logic [refw_pkg::WeightW-1:0] weight;
    logic [refw_pkg::PosW-1:0]    fade;
    logic                         typed;
    logic [refw_pkg::WeightW-1:0] exp_weight;
    logic [refw_pkg::FrameW-1:0]  exp_frame;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  refw_in_if  in_ch ();
  refw_out_if out_ch ();
  refw_cfg_if cfg_ch ();

  run_edge_fade_weighting DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #4 clk_i = ~clk_i;

  // Directed stimulus; typed expectations only where they are obvious.
  row_t dir_rows [27] = '{
    '{ROW_FRAME, 1'b1, 1'b0, 1'b1, 32'h8000_0000, 6'd0, 1'b1, 32'h8000_0000, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 6'd0, 1'b1, 32'hFFFF_FFFF, 16'd1},
    '{ROW_FRAME, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 6'd0, 1'b1, 32'h0000_0000, 16'd3},
    '{ROW_FADE,  1'b0, 1'b0, 1'b0, 32'h0,         6'd4, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b1, 1'b0, 1'b1, 32'h8000_0000, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b0, 1'b1, 32'h4000_0000, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b0, 1'b1, 32'h1234_5678, 6'd0, 1'b0, 32'h0, 16'd0},
    // delay line full: oldest leaves, no fade-in in the first run
    '{ROW_FRAME, 1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF, 6'd0, 1'b1, 32'h8000_0000, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b0, 1'b1, 32'h8000_0000, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b1, 1'b1, 32'h6000_0000, 6'd0, 1'b0, 32'h0, 16'd0},
    // no first mark after a last mark: inner run
    '{ROW_FRAME, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b1, 1'b0, 1'b1, 32'h8000_0000, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b0, 1'b1, 32'h5555_5555, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FADE,  1'b0, 1'b0, 1'b0, 32'h0,         6'd63, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FADE,  1'b0, 1'b0, 1'b0, 32'h0,         6'd1, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b1, 1'b0, 1'b1, 32'hABCD_EF01, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b0, 1'b1, 32'h0000_0001, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b1, 1'b0, 32'h0000_0000, 6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 16'd0},
    // fade off with an entry still held
    '{ROW_FADE,  1'b0, 1'b0, 1'b0, 32'h0,         6'd0, 1'b0, 32'h0, 16'd0},
    '{ROW_FRAME, 1'b0, 1'b1, 1'b1, 32'h8000_0000, 6'd0, 1'b0, 32'h0, 16'd0}
  };

  // predictor state
  faded_t      due_weights[$];
  held_t       held_q[$];
  int unsigned run_pos;
  bit          in_first_run;
  logic [refw_pkg::FrameW-1:0] frame_ctr;
  logic [refw_pkg::PosW-1:0]   fade_reg;

  int unsigned fails = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  function automatic logic [refw_pkg::WeightW-1:0] fade_scale(
      logic [refw_pkg::WeightW-1:0] w, int unsigned m, int unsigned f);
    logic [63:0] prod;
    if (f == 0) return w;
    if (m > f) m = f;
    prod = 64'(w) * 64'(m);
    return refw_pkg::WeightW'(prod / 64'(f));
  endfunction

  function automatic void flush_held(int unsigned f, bit fade_out);
    int unsigned m;
    int unsigned tail;
    for (int i = 0; i < held_q.size(); i++) begin
      m = held_q[i].start_pos;
      if (fade_out) begin
        tail = held_q.size() - i;
        if (tail < m) m = tail;
      end
      due_weights.push_back('{fade_scale(held_q[i].weight, m, f), held_q[i].frame, 1'b0});
    end
    held_q.delete();
  endfunction

  function automatic void fade_frame(bit first_f, bit last_f, bit present,
                                     logic [refw_pkg::WeightW-1:0] w);
    int unsigned f;
    int unsigned n0;
    logic [refw_pkg::FrameW-1:0] idx;
    held_t h;
    f = (fade_reg > refw_pkg::PosW'(refw_pkg::FadeMax)) ? refw_pkg::FadeMax : 32'(fade_reg);
    n0 = due_weights.size();
    if (first_f) begin
      flush_held(f, 1'b1);
      run_pos = 0;
      in_first_run = 1'b1;
      frame_ctr = '0;
    end
    idx = frame_ctr;
    frame_ctr++;
    if (present) begin
      if (run_pos < refw_pkg::FadeMax) run_pos++;
      while (held_q.size() > 0 && held_q.size() >= f) begin
        h = held_q.pop_front();
        due_weights.push_back('{fade_scale(h.weight, h.start_pos, f), h.frame, 1'b0});
      end
      if (f == 0) begin
        due_weights.push_back('{w, idx, 1'b0});
      end else begin
        held_q.push_back('{w, idx, in_first_run ? refw_pkg::FadeMax : run_pos});
      end
      if (last_f) begin
        flush_held(f, 1'b0);
        run_pos = 0;
        in_first_run = 1'b0;
      end
    end else begin
      flush_held(f, 1'b1);
      run_pos = 0;
      in_first_run = 1'b0;
    end
    if (due_weights.size() > n0) due_weights[$].last = 1'b1;
  endfunction

  function automatic logic [refw_pkg::WeightW-1:0] rand_weight();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [refw_pkg::PosW-1:0] pick_fade();
    case ($urandom_range(9))
      0: return 6'd0;
      1: return 6'd32;
      2: return 6'd63;
      3: return 6'($urandom_range(33, 63));
      default: return 6'($urandom_range(1, 8));
    endcase
  endfunction

  // Wait until every expected result is out and the block has settled.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (due_weights.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_fade(logic [refw_pkg::PosW-1:0] value);
    drain();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.fade_length <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    fade_reg = value;
  endtask

  task automatic send_frame(bit first_f, bit last_f, bit present,
                            logic [refw_pkg::WeightW-1:0] w, bit typed = 1'b0,
                            logic [refw_pkg::WeightW-1:0] exp_w = '0,
                            logic [refw_pkg::FrameW-1:0] exp_fr = '0);
    int unsigned n0;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.first_frame <= first_f;
    in_ch.last_frame  <= last_f;
    in_ch.present     <= present;
    in_ch.weight_in   <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    n0 = due_weights.size();
    fade_frame(first_f, last_f, present, w);
    if (typed) begin
      while (due_weights.size() > n0) void'(due_weights.pop_back());
      due_weights.push_back('{exp_w, exp_fr, 1'b1});
    end
  endtask

  // Mostly well-formed sequences with random gaps, some broken ones, some noise.
  task automatic run_random(int unsigned items);
    int unsigned sent;
    int unsigned len;
    int unsigned gap_pct;
    bit mark_first;
    bit mark_last;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 15) begin
        send_frame(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   rand_weight());
        sent++;
      end else begin
        len = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 45);
        case ($urandom_range(4))
          0, 1: gap_pct = 0;
          2: gap_pct = 10;
          3: gap_pct = 30;
          default: gap_pct = 60;
        endcase
        mark_first = $urandom_range(99) >= 10;
        mark_last  = $urandom_range(99) >= 10;
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 2) write_fade(pick_fade());
          send_frame(mark_first && k == 0, mark_last && k == len - 1,
                     $urandom_range(99) >= gap_pct, rand_weight());
        end
        sent += len;
        if ($urandom_range(99) < 20) write_fade(pick_fade());
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    faded_t exp_r;
    if (out_ch.valid && out_ch.ready) begin
      if (due_weights.size() == 0) begin
        $error("result with no expectation: weight_out %h frame_index %0d",
               out_ch.weight_out, out_ch.frame_index);
        fails++;
      end else begin
        exp_r = due_weights.pop_front();
        if (out_ch.weight_out !== exp_r.weight) begin
          $error("weight_out: expected %h, got %h", exp_r.weight, out_ch.weight_out);
          fails++;
        end
        if (out_ch.frame_index !== exp_r.frame) begin
          $error("frame_index: expected %0d, got %0d", exp_r.frame, out_ch.frame_index);
          fails++;
        end
        if (out_ch.last_result !== exp_r.last) begin
          $error("last_result: expected %b, got %b", exp_r.last, out_ch.last_result);
          fails++;
        end
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.first_frame  = 1'b0;
    in_ch.last_frame   = 1'b0;
    in_ch.present      = 1'b0;
    in_ch.weight_in    = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.fade_length = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_pos        = 0;
    in_first_run   = 1'b1;
    frame_ctr      = '0;
    fade_reg       = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_FADE) begin
        write_fade(dir_rows[r].fade);
      end else begin
        send_frame(dir_rows[r].first_f, dir_rows[r].last_f, dir_rows[r].present,
                   dir_rows[r].weight, dir_rows[r].typed, dir_rows[r].exp_weight,
                   dir_rows[r].exp_frame);
      end
    end

    write_fade(pick_fade());
    send_idle_pct  = 30;
    recv_stall_pct = 65;
    run_random(150);

    write_fade(pick_fade());
    send_idle_pct  = 65;
    recv_stall_pct = 30;
    run_random(150);

    write_fade(pick_fade());
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(150);

    drain();
    if (fails == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
